>>> src/pth_sensor_compensation_macros.svh
// Assertion macros for the sensor compensation block.
`ifndef PTH_SENSOR_COMPENSATION_MACROS_SVH
`define PTH_SENSOR_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define PTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, held off during reset.
`define PTH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PTH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> src/pth_pkg.sv
package pth_pkg;

    typedef logic [63:0] t_w64;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_in_item;

    typedef struct packed {
        logic signed [11:0] temperature_tenths;
        logic [31:0]        pressure_value;
        logic [6:0]         humidity_percent;
    } t_out_item;

    // register indexes
    localparam logic [2:0] REG_TEMP    = 3'd0;
    localparam logic [2:0] REG_PRESS_A = 3'd1;
    localparam logic [2:0] REG_PRESS_B = 3'd2;
    localparam logic [2:0] REG_PRESS_C = 3'd3;
    localparam logic [2:0] REG_HUM     = 3'd4;
    localparam logic [2:0] REG_TRIM    = 3'd5;

    localparam logic [7:0] TRIM_RESET = 8'hF1;   // -15

    // edges from accept to the edge that takes the result
    localparam int unsigned LATENCY = 91;

    localparam t_w64 P_T_OFFSET = 64'd128000;
    localparam t_w64 H_T_OFFSET = 64'd76800;
    localparam t_w64 HUM_MAX    = 64'd419430400;

    // ceil(2^30 / 100): exact quotient by 100 for any 23-bit digit step
    localparam logic [46:0] DIV100_MUL = 47'd10737419;

    function automatic t_w64 asr(t_w64 x, int unsigned n);
        return t_w64'($signed(x) >>> n);
    endfunction

    function automatic t_w64 sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_w64 sx12(logic [11:0] v);
        return {{52{v[11]}}, v};
    endfunction

    function automatic t_w64 sx8(logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

endpackage

>>> src/pth_mul.sv
// 64 x 64 product modulo 2^64, two register stages.
module pth_mul (
    input  logic          i_clk,
    input  pth_pkg::t_w64 i_a,
    input  pth_pkg::t_w64 i_b,
    output pth_pkg::t_w64 o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [63:0] w_lh;
    logic [63:0] w_hl;

    assign w_lh = i_a[31:0] * i_b[63:32];
    assign w_hl = i_a[63:32] * i_b[31:0];

    always_ff @(posedge i_clk) begin
        r_ll <= i_a[31:0] * i_b[31:0];
        r_lh <= w_lh[31:0];
        r_hl <= w_hl[31:0];
        r_p  <= r_ll + {r_lh + r_hl, 32'd0};
    end

    assign o_p = r_p;
endmodule

>>> src/pth_dly.sv
// Fixed delay line for side data.
module pth_dly #(
    parameter int unsigned W = 64,
    parameter int unsigned N = 2
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_pipe [N];

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_d;
        for (int i = 1; i < N; i++) begin
            r_pipe[i] <= r_pipe[i-1];
        end
    end

    assign o_q = r_pipe[N-1];
endmodule

>>> src/pth_div.sv
// Signed 64-bit divide, truncating toward zero. One quotient bit per stage,
// 66 register stages in all. Zero divisor gives a meaningless quotient.
module pth_div (
    input  logic          i_clk,
    input  pth_pkg::t_w64 i_a,
    input  pth_pkg::t_w64 i_b,
    output pth_pkg::t_w64 o_q
);
    logic [63:0] r_rem [65];
    logic [63:0] r_num [65];
    logic [63:0] r_den [65];
    logic        r_neg [65];
    logic [63:0] r_q;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= 64'd0;
        r_num[0] <= i_a[63] ? 64'd0 - i_a : i_a;
        r_den[0] <= i_b[63] ? 64'd0 - i_b : i_b;
        r_neg[0] <= i_a[63] ^ i_b[63];
    end

    for (genvar g = 0; g < 64; g++) begin : g_step
        logic [64:0] w_t;
        logic [64:0] w_d;
        logic        w_ge;
        assign w_t  = {r_rem[g], r_num[g][63]};
        assign w_d  = w_t - {1'b0, r_den[g]};
        assign w_ge = (w_t >= {1'b0, r_den[g]});
        always_ff @(posedge i_clk) begin
            r_rem[g+1] <= w_ge ? w_d[63:0] : w_t[63:0];
            r_num[g+1] <= {r_num[g][62:0], w_ge};
            r_den[g+1] <= r_den[g];
            r_neg[g+1] <= r_neg[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_neg[64] ? 64'd0 - r_num[64] : r_num[64];
    end

    assign o_q = r_q;
endmodule

>>> src/pth_sensor_compensation.sv
// Integer compensation of one pressure / temperature / humidity sample.
//
// Input: an item (raw pressure, temperature, humidity) is taken at each
// rising edge with start high and busy low. busy is always low: the datapath
// is a fixed pipeline and takes a new item every cycle.
// Output: each item yields one result, shown on o_result for one cycle with
// o_strobe high. Results leave in accept order. The receiver cannot stall,
// so nothing is held back.
// Latency is set by the 66-stage long divider of the pressure path (one bit
// per stage), the 2-stage 64-bit multipliers around it and the 6-stage
// divide by 100 (sign, four 16-bit digit steps, sign).
// Throughput: one item per cycle, sustained.
// Config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high.
// Writes only while no item is in flight; coefficients are read live.
// Indexes beyond 5 are ignored.
// Reset (synchronous, active low) clears all in-flight valid bits and sets
// the coefficients to zero and the temperature trim to -15.
`include "pth_sensor_compensation_macros.svh"

module pth_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pth_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output pth_pkg::t_out_item o_result,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);
    localparam int unsigned LAT = pth_pkg::LATENCY;

    // config registers
    logic [47:0] r_tc, r_pa, r_pb, r_pc;
    logic [63:0] r_hc;
    logic [7:0]  r_trim;

    // valid bit per stage
    logic [LAT:1] r_vld;

    // stage 1 input capture
    pth_pkg::t_in_item r_in;

    pth_pkg::t_w64 c_t1, c_t2, c_t3;
    pth_pkg::t_w64 c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
    pth_pkg::t_w64 c_h1, c_h2, c_h3, c_h4, c_h5, c_h6, c_trim;

    pth_pkg::t_w64 w_rt, w_rp, w_rh, w_rpd, w_rhd;
    pth_pkg::t_w64 w_ma1, w_ma2, w_ma1d, w_mb, w_mt, w_ts;
    pth_pkg::t_w64 r_tf, w_pv1, w_hv1;
    logic [11:0]   r_ts, w_tsd;
    pth_pkg::t_w64 w_q1, w_q2, w_q3, w_q4, w_q5, w_q2d, w_q3d, w_q6, w_q7;
    pth_pkg::t_w64 r_rv2, r_rv1a, w_den, w_pq, w_pqd, w_r1, w_r2, w_r2d, w_r3;
    pth_pkg::t_w64 r_psum, r_pres;
    logic          w_zero, w_zd;
    pth_pkg::t_w64 w_h1, w_h2, w_h3, w_ha, w_had, w_h4, w_h5, w_hb;
    pth_pkg::t_w64 w_x, w_xd, w_hd, w_h6, w_h7, w_xx;
    logic [6:0]    r_hum, w_humd;
    pth_pkg::t_out_item r_out;

    // divide by 100 stages
    logic [63:0] r_dm [4];
    logic [6:0]  r_dr [4];
    logic [63:0] r_dq [5];
    logic        r_dn [5];

    assign busy = 1'b0;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc   <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_pc   <= '0;
            r_hc   <= '0;
            r_trim <= pth_pkg::TRIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pth_pkg::REG_TEMP:    r_tc   <= i_cfg_data[47:0];
                pth_pkg::REG_PRESS_A: r_pa   <= i_cfg_data[47:0];
                pth_pkg::REG_PRESS_B: r_pb   <= i_cfg_data[47:0];
                pth_pkg::REG_PRESS_C: r_pc   <= i_cfg_data[47:0];
                pth_pkg::REG_HUM:     r_hc   <= i_cfg_data;
                pth_pkg::REG_TRIM:    r_trim <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign c_t1   = {48'd0, r_tc[15:0]};
    assign c_t2   = pth_pkg::sx16(r_tc[31:16]);
    assign c_t3   = pth_pkg::sx16(r_tc[47:32]);
    assign c_p1   = {48'd0, r_pa[15:0]};
    assign c_p2   = pth_pkg::sx16(r_pa[31:16]);
    assign c_p3   = pth_pkg::sx16(r_pa[47:32]);
    assign c_p4   = pth_pkg::sx16(r_pb[15:0]);
    assign c_p5   = pth_pkg::sx16(r_pb[31:16]);
    assign c_p6   = pth_pkg::sx16(r_pb[47:32]);
    assign c_p7   = pth_pkg::sx16(r_pc[15:0]);
    assign c_p8   = pth_pkg::sx16(r_pc[31:16]);
    assign c_p9   = pth_pkg::sx16(r_pc[47:32]);
    assign c_h1   = {56'd0, r_hc[7:0]};
    assign c_h2   = pth_pkg::sx16(r_hc[23:8]);
    assign c_h3   = {56'd0, r_hc[31:24]};
    assign c_h4   = pth_pkg::sx12(r_hc[43:32]);
    assign c_h5   = pth_pkg::sx12(r_hc[55:44]);
    assign c_h6   = pth_pkg::sx8(r_hc[63:56]);
    assign c_trim = pth_pkg::sx8(r_trim);

    // ---------------- valid pipe and input capture ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    assign w_rt = {44'd0, r_in.raw_temperature};
    assign w_rp = {44'd0, r_in.raw_pressure};
    assign w_rh = {48'd0, r_in.raw_humidity};

    // ---------------- fine temperature (stages 1..6) ----------------
    pth_mul u_ma1 (.i_clk, .i_a((w_rt >> 3) - (c_t1 << 1)), .i_b(c_t2), .o_p(w_ma1));
    pth_mul u_ma2 (.i_clk, .i_a((w_rt >> 4) - c_t1), .i_b((w_rt >> 4) - c_t1),
                   .o_p(w_ma2));
    pth_dly #(.W(64), .N(2)) u_ma1d (.i_clk, .i_d(w_ma1), .o_q(w_ma1d));
    pth_mul u_mb (.i_clk, .i_a(pth_pkg::asr(w_ma2, 12)), .i_b(c_t3), .o_p(w_mb));

    always_ff @(posedge i_clk) begin
        r_tf <= pth_pkg::asr(w_ma1d, 11) + pth_pkg::asr(w_mb, 14);
    end

    // ---------------- temperature result (stages 6..9) ----------------
    pth_mul u_mt (.i_clk, .i_a(pth_pkg::asr((r_tf << 2) + r_tf + 64'd128, 8)),
                  .i_b(64'd6553), .o_p(w_mt));
    assign w_ts = pth_pkg::asr(w_mt, 16) + c_trim;

    always_ff @(posedge i_clk) begin
        if ($signed(w_ts) < -64'sd2048) begin
            r_ts <= 12'h800;
        end else if ($signed(w_ts) > 64'sd2047) begin
            r_ts <= 12'h7FF;
        end else begin
            r_ts <= w_ts[11:0];
        end
    end

    pth_dly #(.W(12), .N(81)) u_tsd (.i_clk, .i_d(r_ts), .o_q(w_tsd));

    // ---------------- pressure terms (stages 6..13) ----------------
    assign w_pv1 = r_tf - pth_pkg::P_T_OFFSET;

    pth_mul u_q1 (.i_clk, .i_a(w_pv1), .i_b(w_pv1), .o_p(w_q1));
    pth_mul u_q2 (.i_clk, .i_a(w_pv1), .i_b(c_p5),  .o_p(w_q2));
    pth_mul u_q3 (.i_clk, .i_a(w_pv1), .i_b(c_p2),  .o_p(w_q3));
    pth_mul u_q4 (.i_clk, .i_a(w_q1),  .i_b(c_p6),  .o_p(w_q4));
    pth_mul u_q5 (.i_clk, .i_a(w_q1),  .i_b(c_p3),  .o_p(w_q5));
    pth_dly #(.W(64), .N(2)) u_q2d (.i_clk, .i_d(w_q2), .o_q(w_q2d));
    pth_dly #(.W(64), .N(2)) u_q3d (.i_clk, .i_d(w_q3), .o_q(w_q3d));

    always_ff @(posedge i_clk) begin
        r_rv2  <= w_q4 + (w_q2d << 17) + (c_p4 << 35);
        r_rv1a <= pth_pkg::asr(w_q5, 8) + (w_q3d << 12);
    end

    pth_dly #(.W(64), .N(10)) u_rpd (.i_clk, .i_d(w_rp), .o_q(w_rpd));

    pth_mul u_q6 (.i_clk, .i_a((64'd1 << 47) + r_rv1a), .i_b(c_p1), .o_p(w_q6));
    pth_mul u_q7 (.i_clk, .i_a(((64'd1048576 - w_rpd) << 31) - r_rv2),
                  .i_b(64'd3125), .o_p(w_q7));

    assign w_den  = pth_pkg::asr(w_q6, 33);
    assign w_zero = (w_den == 64'd0);
    pth_dly #(.W(1), .N(77)) u_zd (.i_clk, .i_d(w_zero), .o_q(w_zd));

    // ---------------- pressure divide and trim (stages 13..84) ----------------
    pth_div u_div_p (.i_clk, .i_a(w_q7), .i_b(w_den), .o_q(w_pq));

    pth_mul u_r1 (.i_clk, .i_a(pth_pkg::asr(w_pq, 13)), .i_b(pth_pkg::asr(w_pq, 13)),
                  .o_p(w_r1));
    pth_mul u_r2 (.i_clk, .i_a(c_p8), .i_b(w_pq), .o_p(w_r2));
    pth_mul u_r3 (.i_clk, .i_a(w_r1), .i_b(c_p9), .o_p(w_r3));
    pth_dly #(.W(64), .N(2)) u_r2d (.i_clk, .i_d(w_r2), .o_q(w_r2d));
    pth_dly #(.W(64), .N(4)) u_pqd (.i_clk, .i_d(w_pq), .o_q(w_pqd));

    always_ff @(posedge i_clk) begin
        r_psum <= pth_pkg::asr(w_pqd + pth_pkg::asr(w_r3, 25) + pth_pkg::asr(w_r2d, 19), 8)
                + (c_p7 << 4);
    end

    // ---------------- Q24.8 Pa to hundredths (stages 85..90) ----------------
    // Divide the magnitude by 100 a 16-bit digit per stage, most significant
    // first; the running remainder stays below 100, so each step is a 23-bit
    // reciprocal multiply. Sign is put back at the end (truncation to zero).
    always_ff @(posedge i_clk) begin
        r_dm[0] <= r_psum[63] ? 64'd0 - r_psum : r_psum;
        r_dr[0] <= 7'd0;
        r_dq[0] <= 64'd0;
        r_dn[0] <= r_psum[63];
    end

    for (genvar g = 0; g < 4; g++) begin : g_dv
        logic [22:0] w_v;
        logic [46:0] w_prod;
        logic [15:0] w_q;
        assign w_v    = {r_dr[g], r_dm[g][63-16*g -: 16]};
        assign w_prod = {24'd0, w_v} * pth_pkg::DIV100_MUL;
        assign w_q    = w_prod[45:30];
        always_ff @(posedge i_clk) begin
            r_dq[g+1] <= {r_dq[g][47:0], w_q};
            r_dn[g+1] <= r_dn[g];
        end
        if (g < 3) begin : g_rem
            logic [22:0] w_qm;
            logic [22:0] w_rn;
            assign w_qm = {7'd0, w_q} * 23'd100;
            assign w_rn = w_v - w_qm;
            always_ff @(posedge i_clk) begin
                r_dr[g+1] <= w_rn[6:0];
                r_dm[g+1] <= r_dm[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pres <= r_dn[4] ? 64'd0 - r_dq[4] : r_dq[4];
    end

    // ---------------- humidity (stages 6..19) ----------------
    assign w_hv1 = r_tf - pth_pkg::H_T_OFFSET;

    pth_mul u_h1 (.i_clk, .i_a(c_h5),  .i_b(w_hv1), .o_p(w_h1));
    pth_mul u_h2 (.i_clk, .i_a(w_hv1), .i_b(c_h6),  .o_p(w_h2));
    pth_mul u_h3 (.i_clk, .i_a(w_hv1), .i_b(c_h3),  .o_p(w_h3));
    pth_dly #(.W(64), .N(7)) u_rhd (.i_clk, .i_d(w_rh), .o_q(w_rhd));

    assign w_ha = pth_pkg::asr((w_rhd << 14) - (c_h4 << 20) - w_h1 + 64'd16384, 15);
    pth_dly #(.W(64), .N(4)) u_had (.i_clk, .i_d(w_ha), .o_q(w_had));

    pth_mul u_h4 (.i_clk, .i_a(pth_pkg::asr(w_h2, 10)),
                  .i_b(pth_pkg::asr(w_h3, 11) + 64'd32768), .o_p(w_h4));
    pth_mul u_h5 (.i_clk, .i_a(pth_pkg::asr(w_h4, 10) + 64'd2097152), .i_b(c_h2),
                  .o_p(w_h5));
    assign w_hb = pth_pkg::asr(w_h5 + 64'd8192, 14);

    pth_mul u_hx (.i_clk, .i_a(w_had), .i_b(w_hb), .o_p(w_x));
    assign w_hd = pth_pkg::asr(w_x, 15);
    pth_mul u_h6 (.i_clk, .i_a(w_hd), .i_b(w_hd), .o_p(w_h6));
    pth_mul u_h7 (.i_clk, .i_a(pth_pkg::asr(w_h6, 7)), .i_b(c_h1), .o_p(w_h7));
    pth_dly #(.W(64), .N(4)) u_xd (.i_clk, .i_d(w_x), .o_q(w_xd));

    assign w_xx = w_xd - pth_pkg::asr(w_h7, 4);

    // clamp to 0..100 % in Q42.22
    always_ff @(posedge i_clk) begin
        if (w_xx[63]) begin
            r_hum <= 7'd0;
        end else if (w_xx > pth_pkg::HUM_MAX) begin
            r_hum <= 7'd100;
        end else begin
            r_hum <= w_xx[28:22];
        end
    end

    pth_dly #(.W(7), .N(71)) u_humd (.i_clk, .i_d(r_hum), .o_q(w_humd));

    // ---------------- output register (stage 91) ----------------
    always_ff @(posedge i_clk) begin
        r_out.temperature_tenths <= w_tsd;
        r_out.pressure_value     <= w_zd ? 32'd0 : r_pres[31:0];
        r_out.humidity_percent   <= w_humd;
    end

    assign o_strobe = r_vld[LAT];
    assign o_result = r_out;

    // ---------------- checks ----------------
    `PTH_ASSERT_IMP(a_hum_range, i_clk, i_rst_n, o_strobe, o_result.humidity_percent <= 7'd100, "humidity above 100")
    `PTH_ASSERT_NXT(a_zero_div, i_clk, i_rst_n, r_vld[LAT-1] && w_zd, o_result.pressure_value == 32'd0, "zero divisor gave nonzero pressure")

endmodule

>>> tb/sv/tb_pth_sensor_compensation.sv
`timescale 1ns / 100ps

module tb_pth_sensor_compensation;

    typedef logic [63:0] t_w64;

    // Register indexes with no register behind them; writes must be dropped.
    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;

    // Typical factory calibration from the published example.
    localparam t_w64 CAL_TEMP    = 64'h0000_FC18_6743_6B70;
    localparam t_w64 CAL_PRESS_A = 64'h0000_0BD0_D643_8E7D;
    localparam t_w64 CAL_PRESS_B = 64'h0000_FFF9_008C_0B27;
    localparam t_w64 CAL_PRESS_C = 64'h0000_1770_C6F8_3C8C;
    localparam t_w64 CAL_HUM     = {8'h1E, 12'h032, 12'h139, 8'h00, 16'h016A, 8'h4B};
    localparam t_w64 ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_w64 MAX_POS     = 64'h7FFF_7FFF_7FFF_7FFF;

    localparam int unsigned N_PHASES   = 8;
    localparam int unsigned PHASE_ITEMS = 104;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [2:0]         idx;       // config rows
        t_w64               data;
        pth_pkg::t_in_item  item;      // item rows
        bit                 fixed;     // expected result typed in below
        pth_pkg::t_out_item result;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    pth_pkg::t_in_item  i_item = '0;
    logic               o_strobe;
    pth_pkg::t_out_item o_result;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = pth_pkg::REG_TEMP;
    logic [63:0]        i_cfg_data = '0;

    pth_sensor_compensation u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Local copy of the calibration registers, updated as they are written.
    t_w64               cal_regs [0:5];
    pth_pkg::t_out_item pending_results [$];
    int unsigned err_count = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic t_w64 sar(t_w64 x, int unsigned n);
        return t_w64'($signed(x) >>> n);
    endfunction

    function automatic t_w64 ufld(t_w64 v, int unsigned lo, int unsigned bits);
        return (v >> lo) & ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic t_w64 sfld(t_w64 v, int unsigned lo, int unsigned bits);
        t_w64 x;
        x = ufld(v, lo, bits);
        if (x[bits-1])
            x = x | ~((64'd1 << bits) - 64'd1);
        return x;
    endfunction

    // Signed divide truncating toward zero, wrapping like the hardware.
    function automatic t_w64 div_tz(t_w64 a, t_w64 b);
        t_w64 ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic pth_pkg::t_out_item compensate(pth_pkg::t_in_item it);
        t_w64 rp, rt, rh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t_w64 h1, h2, h3, h4, h5, h6, v1, v2, d, tf, p, a, b, x;
        longint ts, hs;
        pth_pkg::t_out_item r;
        rp = t_w64'(it.raw_pressure);
        rt = t_w64'(it.raw_temperature);
        rh = t_w64'(it.raw_humidity);
        t1 = ufld(cal_regs[0], 0, 16); t2 = sfld(cal_regs[0], 16, 16);
        t3 = sfld(cal_regs[0], 32, 16);
        p1 = ufld(cal_regs[1], 0, 16); p2 = sfld(cal_regs[1], 16, 16);
        p3 = sfld(cal_regs[1], 32, 16);
        p4 = sfld(cal_regs[2], 0, 16); p5 = sfld(cal_regs[2], 16, 16);
        p6 = sfld(cal_regs[2], 32, 16);
        p7 = sfld(cal_regs[3], 0, 16); p8 = sfld(cal_regs[3], 16, 16);
        p9 = sfld(cal_regs[3], 32, 16);
        h1 = ufld(cal_regs[4], 0, 8);  h2 = sfld(cal_regs[4], 8, 16);
        h3 = ufld(cal_regs[4], 24, 8); h4 = sfld(cal_regs[4], 32, 12);
        h5 = sfld(cal_regs[4], 44, 12); h6 = sfld(cal_regs[4], 56, 8);

        // fine temperature
        v1 = sar(((rt >> 3) - (t1 << 1)) * t2, 11);
        d  = (rt >> 4) - t1;
        v2 = sar(sar(d * d, 12) * t3, 14);
        tf = v1 + v2;
        ts = $signed(sar(sar(tf * 64'd5 + 64'd128, 8) * 64'd6553, 16));
        ts += $signed(sfld(cal_regs[5], 0, 8));
        if (ts < -2048) ts = -2048;
        if (ts > 2047) ts = 2047;
        r.temperature_tenths = ts[11:0];

        // pressure, zero when the divisor collapses
        v1 = tf - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 += (v1 * p5) << 17;
        v2 += p4 << 35;
        v1 = sar(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sar(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            r.pressure_value = '0;
        end else begin
            p = 64'd1048576 - rp;
            p = div_tz(((p << 31) - v2) * 64'd3125, v1);
            a = sar(p9 * sar(p, 13) * sar(p, 13), 25);
            b = sar(p8 * p, 19);
            p = sar(p + a + b, 8) + (p7 << 4);
            x = div_tz(p, 64'd100);
            r.pressure_value = x[31:0];
        end

        // humidity, clamped before scaling
        v1 = tf - 64'd76800;
        a = sar((rh << 14) - (h4 << 20) - h5 * v1 + 64'd16384, 15);
        b = sar(v1 * h6, 10) * (sar(v1 * h3, 11) + 64'd32768);
        b = sar((sar(b, 10) + 64'd2097152) * h2 + 64'd8192, 14);
        x = a * b;
        d = sar(x, 15);
        x = x - sar(sar(d * d, 7) * h1, 4);
        hs = $signed(x);
        if (hs < 0) hs = 0;
        if (hs > 419430400) hs = 419430400;
        r.humidity_percent = hs[28:22];
        return r;
    endfunction

    // Results are stable around the falling edge; check them there.
    always @(negedge i_clk) begin
        pth_pkg::t_out_item e;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = pending_results.pop_front();
                if (o_result.temperature_tenths !== e.temperature_tenths)
                    report_mismatch($sformatf("temperature %0d, expected %0d",
                        o_result.temperature_tenths, e.temperature_tenths));
                if (o_result.pressure_value !== e.pressure_value)
                    report_mismatch($sformatf("pressure %0d, expected %0d",
                        o_result.pressure_value, e.pressure_value));
                if (o_result.humidity_percent !== e.humidity_percent)
                    report_mismatch($sformatf("humidity %0d, expected %0d",
                        o_result.humidity_percent, e.humidity_percent));
            end
        end
    end

    // Present one item and hold it until accepted. Leaves start high; the
    // caller lowers it only when it goes idle.
    task automatic push_item(input pth_pkg::t_in_item it, input bit fixed,
                             input pth_pkg::t_out_item res);
        i_item <= it;
        start  <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        pending_results.push_back(fixed ? res : compensate(it));
    endtask

    task automatic go_idle(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Only called while the pipeline is empty. The enable drops for one
    // cycle before the next write.
    task automatic write_reg(input logic [2:0] idx, input t_w64 data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            pth_pkg::REG_TEMP, pth_pkg::REG_PRESS_A, pth_pkg::REG_PRESS_B,
            pth_pkg::REG_PRESS_C:
                cal_regs[idx] = data & 64'h0000_FFFF_FFFF_FFFF;
            pth_pkg::REG_HUM:  cal_regs[idx] = data;
            pth_pkg::REG_TRIM: cal_regs[idx] = data & 64'hFF;
            default: ;
        endcase
    endtask

    task automatic write_all(input t_w64 t, input t_w64 pa, input t_w64 pb,
                             input t_w64 pc, input t_w64 h, input t_w64 trim);
        write_reg(pth_pkg::REG_TEMP, t);
        write_reg(pth_pkg::REG_PRESS_A, pa);
        write_reg(pth_pkg::REG_PRESS_B, pb);
        write_reg(pth_pkg::REG_PRESS_C, pc);
        write_reg(pth_pkg::REG_HUM, h);
        write_reg(pth_pkg::REG_TRIM, trim);
    endtask

    function automatic t_w64 rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Half the items sit near a plausible operating point, the rest are
    // uniform over the full field ranges.
    function automatic pth_pkg::t_in_item rand_item();
        pth_pkg::t_in_item it;
        if ($urandom_range(0, 1)) begin
            it.raw_pressure    = 20'($urandom_range(250000, 600000));
            it.raw_temperature = 20'($urandom_range(400000, 650000));
            it.raw_humidity    = 16'($urandom_range(15000, 45000));
        end else begin
            it.raw_pressure    = 20'($urandom());
            it.raw_temperature = 20'($urandom());
            it.raw_humidity    = 16'($urandom());
        end
        return it;
    endfunction

    t_row directed [$];

    function automatic t_row item_row(input pth_pkg::t_in_item it, input bit fixed,
                                      input pth_pkg::t_out_item res);
        t_row r;
        r.kind = ROW_ITEM; r.idx = pth_pkg::REG_TEMP; r.data = '0;
        r.item = it; r.fixed = fixed; r.result = res;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [2:0] idx, input t_w64 data);
        t_row r;
        r.kind = ROW_CFG; r.idx = idx; r.data = data;
        r.item = '0; r.fixed = 1'b0; r.result = '0;
        return r;
    endfunction

    initial begin
        // With all coefficients at zero the fine temperature is zero, so
        // temperature is just the trim, and both divisor and humidity vanish.
        directed.push_back(item_row('0, 1, '{-12'sd15, 32'd0, 7'd0}));
        directed.push_back(item_row('1, 1, '{-12'sd15, 32'd0, 7'd0}));
        directed.push_back(item_row({20'hAAAAA, 20'h55555, 16'hAAAA}, 1,
                                    '{-12'sd15, 32'd0, 7'd0}));
        directed.push_back(item_row({20'h55555, 20'hAAAAA, 16'h5555}, 1,
                                    '{-12'sd15, 32'd0, 7'd0}));
        // trim extremes, bits above the register width dropped
        directed.push_back(cfg_row(pth_pkg::REG_TRIM, 64'hFFFF_FFFF_FFFF_FF7F));
        directed.push_back(item_row('1, 1, '{12'sd127, 32'd0, 7'd0}));
        directed.push_back(cfg_row(pth_pkg::REG_TRIM, 64'h80));
        directed.push_back(item_row('0, 1, '{-12'sd128, 32'd0, 7'd0}));
        // writes to unused indexes must change nothing
        directed.push_back(cfg_row(REG_UNUSED_A, ALL_ONES));
        directed.push_back(cfg_row(REG_UNUSED_B, ALL_ONES));
        directed.push_back(item_row('0, 1, '{-12'sd128, 32'd0, 7'd0}));
        // typical calibration
        directed.push_back(cfg_row(pth_pkg::REG_TEMP, CAL_TEMP));
        directed.push_back(cfg_row(pth_pkg::REG_PRESS_A, CAL_PRESS_A));
        directed.push_back(cfg_row(pth_pkg::REG_PRESS_B, CAL_PRESS_B));
        directed.push_back(cfg_row(pth_pkg::REG_PRESS_C, CAL_PRESS_C));
        directed.push_back(cfg_row(pth_pkg::REG_HUM, CAL_HUM));
        directed.push_back(cfg_row(pth_pkg::REG_TRIM, 64'hF1));
        directed.push_back(item_row({20'd415148, 20'd519888, 16'd30000}, 0, '0));
        directed.push_back(item_row({20'd0, 20'd0, 16'd0}, 0, '0));
        directed.push_back(item_row('1, 0, '0));
        directed.push_back(item_row({20'd300000, 20'd600000, 16'hFFFF}, 0, '0));
        // extreme coefficients: saturation and wrap
        directed.push_back(cfg_row(pth_pkg::REG_TEMP, MAX_POS));
        directed.push_back(item_row({20'd415148, 20'hFFFFF, 16'd30000}, 0, '0));
        directed.push_back(item_row({20'd415148, 20'd0, 16'd30000}, 0, '0));
        directed.push_back(cfg_row(pth_pkg::REG_TEMP, ALL_ONES));
        directed.push_back(item_row({20'd415148, 20'h80000, 16'd0}, 0, '0));
    end

    initial begin
        int unsigned idle_pct;
        pth_pkg::t_in_item it;
        cal_regs[0] = '0; cal_regs[1] = '0; cal_regs[2] = '0;
        cal_regs[3] = '0; cal_regs[4] = '0;
        cal_regs[5] = t_w64'(pth_pkg::TRIM_RESET);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG) begin
                drain();
                write_reg(directed[k].idx, directed[k].data);
            end else begin
                push_item(directed[k].item, directed[k].fixed, directed[k].result);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph % 8)
                0: write_all(CAL_TEMP, CAL_PRESS_A, CAL_PRESS_B, CAL_PRESS_C,
                             CAL_HUM, 64'hF1);
                1: write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
                2: write_all(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 64'h7F);
                3: write_all(rand64(), rand64() & ~64'hFFFF, rand64(), rand64(),
                             rand64(), 64'h80);
                4: write_all(CAL_TEMP ^ 64'($urandom_range(0, 255)),
                             CAL_PRESS_A ^ 64'($urandom_range(0, 255)),
                             CAL_PRESS_B, CAL_PRESS_C,
                             CAL_HUM ^ 64'($urandom_range(0, 255)), rand64());
                5: write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
                6: write_all(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, 64'h00);
                default: write_all(CAL_TEMP, CAL_PRESS_A, CAL_PRESS_B, CAL_PRESS_C,
                                   rand64(), rand64());
            endcase
            write_reg(REG_UNUSED_A, rand64());
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 67;
                2: idle_pct = 0;
                default: idle_pct = 30;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = rand_item();
                push_item(it, 1'b0, '0);
                // one full stop mid-run, sender waits for the pipeline to empty
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain();
                else if ($urandom_range(0, 99) < idle_pct)
                    go_idle($urandom_range(1, 4));
            end
        end

        drain();
        repeat (pth_pkg::LATENCY + 20) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_pth_sensor_compensation: clean");
        else
            $display("tb_pth_sensor_compensation: errors");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("tb_pth_sensor_compensation: errors");
        $finish;
    end

endmodule
